// ===== rtl/core/dynamic_range_compressor_unit_macros.svh =====
// assertion macros for the dynamic range compressor
// used by drc_ctrl to check its own control sequencing
`ifndef DYNAMIC_RANGE_COMPRESSOR_UNIT_MACROS_SVH
`define DYNAMIC_RANGE_COMPRESSOR_UNIT_MACROS_SVH
`ifndef SYNTH
// same-cycle implication
`define DRC_ASSERT_IMP(lbl, clk_s, rst_s, ante, cons, msg) \
    lbl: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |-> (cons)) \
        else $error(msg);
// next-cycle implication
`define DRC_ASSERT_NXT(lbl, clk_s, rst_s, ante, cons, msg) \
    lbl: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |=> (cons)) \
        else $error(msg);
`else
`define DRC_ASSERT_IMP(lbl, clk_s, rst_s, ante, cons, msg)
`define DRC_ASSERT_NXT(lbl, clk_s, rst_s, ante, cons, msg)
`endif
`endif

// ===== rtl/core/drc_pkg.sv =====
// shared types, constants and elaboration-time table functions
// for the dynamic range compressor; no dependencies
`timescale 1ns / 1ps

package drc_pkg;

    // default parameter values
    localparam int SAMPLE_BITS_DEF    = 24;
    localparam int COEF_BITS_DEF      = 16;
    localparam int LOG_TABLE_BITS_DEF = 6;

    // register and datapath widths
    localparam int THR_W      = 15;
    localparam int IRATIO_W   = 17;
    localparam int COEFR_W    = 16;
    localparam int MAKEUP_W   = 13;
    localparam int SMOOTH_W   = 16;
    localparam int LEVEL_W    = 17;
    localparam int TAB_W      = 17;
    localparam int CFG_DATA_W = 17;
    localparam int CFG_IDX_W  = 3;

    // register reset values
    localparam logic [IRATIO_W-1:0] IRATIO_RST  = 17'd65536;
    localparam logic [COEFR_W-1:0]  RELEASE_RST = 16'd65399;

    // register map
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_THRESHOLD = 3'd0,
        CFG_INV_RATIO = 3'd1,
        CFG_ATTACK    = 3'd2,
        CFG_RELEASE   = 3'd3,
        CFG_MAKEUP    = 3'd4
    } cfg_idx_t;

    typedef struct packed {
        logic [THR_W-1:0]    threshold_db;
        logic [IRATIO_W-1:0] inverse_ratio;
        logic [COEFR_W-1:0]  attack_coef;
        logic [COEFR_W-1:0]  release_coef;
        logic [MAKEUP_W-1:0] makeup_db;
    } cfg_t;

    // controller states
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_NORM,
        ST_TAB,
        ST_INTERP,
        ST_DB,
        ST_RED,
        ST_SMA,
        ST_SMB,
        ST_GAIN,
        ST_EXP,
        ST_PROD,
        ST_OUT
    } ctrl_state_t;

    // datapath operations
    typedef enum logic [3:0] {
        OP_NONE,
        OP_LOAD,
        OP_NORM,
        OP_TAB,
        OP_INTERP,
        OP_DB,
        OP_RED,
        OP_SMA,
        OP_SMB,
        OP_GAIN,
        OP_EXP,
        OP_PROD,
        OP_OUT
    } dp_op_t;

    typedef struct packed {
        dp_op_t op;
    } dp_cmd_t;

    typedef struct packed {
        logic exp_last;
    } dp_status_t;

    // fractional log2 of a Q1.30 mantissa in [1,2], result in Q.16
    function automatic logic [TAB_W-1:0] log2_frac(input logic [63:0] m_in);
        logic [63:0]      m;
        logic [TAB_W-1:0] r;
        m = m_in;
        r = '0;
        if (m >= (64'd1 << 31))
        begin
            return 17'h10000;
        end
        for (int k = 0; k < 16; k++)
        begin
            m = (m * m) >> 30;
            r = r << 1;
            if (m >= (64'd1 << 31))
            begin
                r[0] = 1'b1;
                m    = m >> 1;
            end
        end
        return r;
    endfunction

    // log2(1 + i/2^ltb) in Q.16
    function automatic logic [TAB_W-1:0] log_tab_entry(input int i, input int ltb);
        logic [63:0] m;
        m = ((64'd1 << ltb) + 64'(i)) << (30 - ltb);
        return log2_frac(m);
    endfunction

    // bitwise integer square root
    function automatic logic [63:0] isqrt64(input logic [63:0] a_in);
        logic [63:0] a;
        logic [63:0] res;
        logic [63:0] bitv;
        a    = a_in;
        res  = '0;
        bitv = 64'd1 << 62;
        for (int i = 0; i < 32; i++)
        begin
            if (bitv > a)
            begin
                bitv = bitv >> 2;
            end
        end
        for (int i = 0; i < 32; i++)
        begin
            if (bitv != 64'd0)
            begin
                if (a >= res + bitv)
                begin
                    a   = a - (res + bitv);
                    res = (res >> 1) + bitv;
                end
                else
                begin
                    res = res >> 1;
                end
                bitv = bitv >> 2;
            end
        end
        return res;
    endfunction

    // 2^(2^-k) in Q1.30 by k repeated square roots of two
    function automatic logic [31:0] exp_root(input int k);
        logic [63:0] c;
        c = 64'd1 << 31;
        for (int j = 0; j < k; j++)
        begin
            c = isqrt64(c << 30);
        end
        return 32'(c);
    endfunction

endpackage

// ===== rtl/core/drc_in_if.sv =====
// input sample channel: valid/ready plus one signed sample
// depends on drc_pkg for the default width
`timescale 1ns / 1ps

interface drc_in_if #(
    parameter int SAMPLE_BITS = drc_pkg::SAMPLE_BITS_DEF
);
    logic                   valid;
    logic                   ready;
    logic [SAMPLE_BITS-1:0] in_sample;

    modport source (output valid, output in_sample, input ready);
    modport sink (input valid, input in_sample, output ready);
endinterface

// ===== rtl/core/drc_out_if.sv =====
// result channel: valid/ready plus compressed sample and clip flag
// depends on drc_pkg for the default width
`timescale 1ns / 1ps

interface drc_out_if #(
    parameter int SAMPLE_BITS = drc_pkg::SAMPLE_BITS_DEF
);
    logic                   valid;
    logic                   ready;
    logic [SAMPLE_BITS-1:0] out_sample;
    logic                   clipped;

    modport source (output valid, output out_sample, output clipped, input ready);
    modport sink (input valid, input out_sample, input clipped, output ready);
endinterface

// ===== rtl/core/drc_cfg.sv =====
// configuration register bank, written through a plain write port
// depends on drc_pkg
`timescale 1ns / 1ps

module drc_cfg (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_we,
    input  logic [drc_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [drc_pkg::CFG_DATA_W-1:0]   cfg_wdata,
    output drc_pkg::cfg_t                    cfg
);

    drc_pkg::cfg_t cfg_reg;

    // register writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.threshold_db  <= '0;
            cfg_reg.inverse_ratio <= drc_pkg::IRATIO_RST;
            cfg_reg.attack_coef   <= '0;
            cfg_reg.release_coef  <= drc_pkg::RELEASE_RST;
            cfg_reg.makeup_db     <= '0;
        end
        else if (cfg_we)
        begin
            unique case (drc_pkg::cfg_idx_t'(cfg_index))
                drc_pkg::CFG_THRESHOLD:
                    cfg_reg.threshold_db <= cfg_wdata[drc_pkg::THR_W-1:0];
                drc_pkg::CFG_INV_RATIO:
                    cfg_reg.inverse_ratio <= cfg_wdata[drc_pkg::IRATIO_W-1:0];
                drc_pkg::CFG_ATTACK:
                    cfg_reg.attack_coef <= cfg_wdata[drc_pkg::COEFR_W-1:0];
                drc_pkg::CFG_RELEASE:
                    cfg_reg.release_coef <= cfg_wdata[drc_pkg::COEFR_W-1:0];
                drc_pkg::CFG_MAKEUP:
                    cfg_reg.makeup_db <= cfg_wdata[drc_pkg::MAKEUP_W-1:0];
                default:
                    cfg_reg <= cfg_reg;
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

// ===== rtl/core/drc_datapath.sv =====
// compressor datapath: level detector, gain computer, smoother,
// exponent unit and output rounding; driven by drc_ctrl, uses drc_pkg
`timescale 1ns / 1ps

module drc_datapath #(
    parameter int SAMPLE_BITS    = drc_pkg::SAMPLE_BITS_DEF,
    parameter int COEF_BITS      = drc_pkg::COEF_BITS_DEF,
    parameter int LOG_TABLE_BITS = drc_pkg::LOG_TABLE_BITS_DEF
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  drc_pkg::dp_cmd_t       cmd,
    output drc_pkg::dp_status_t    status,
    input  drc_pkg::cfg_t          cfg,
    input  logic [SAMPLE_BITS-1:0] in_sample,
    output logic [SAMPLE_BITS-1:0] out_sample,
    output logic                   clipped
);

    localparam int S      = SAMPLE_BITS;
    localparam int P_W    = $clog2(SAMPLE_BITS);
    localparam int RW     = SAMPLE_BITS - 1 - LOG_TABLE_BITS;
    localparam int TAB_N  = (1 << LOG_TABLE_BITS) + 1;
    localparam int LG_W   = P_W + 16;
    localparam int DBP_W  = LG_W + 19;
    localparam int DB_W   = DBP_W - 24;
    localparam int ACC_W  = COEF_BITS + 16;
    localparam int SUM_W  = COEF_BITS + 19;
    localparam int PROD_W = SAMPLE_BITS + 32;
    localparam int RND_W  = SAMPLE_BITS + 33;
    localparam int LW     = drc_pkg::LEVEL_W;
    localparam int TW     = drc_pkg::TAB_W;

    localparam logic [S-1:0] TINY_MAX =
        S'(((64'd1 << (SAMPLE_BITS - 1)) - 64'd1) / 64'd1000000);
    localparam logic [RND_W-1:0] HALF    = RND_W'(1) << (SAMPLE_BITS - 1);
    localparam logic [RND_W-1:0] HALF_M1 = HALF - RND_W'(1);
    localparam logic [S-1:0]     HALF_S  = S'(1) << (SAMPLE_BITS - 1);
    localparam logic [S-1:0]     HALF_M1_S = HALF_S - S'(1);
    localparam logic signed [LW-1:0] LEVEL_FLOOR = -17'sd30720;
    localparam logic [COEF_BITS:0] CONE = (COEF_BITS+1)'(1) << COEF_BITS;

    // constant tables
    logic [TW-1:0] log_tab [0:TAB_N-1];
    logic [31:0]   root_tab [0:15];

    for (genvar gi = 0; gi < TAB_N; gi++)
    begin : g_log_tab
        assign log_tab[gi] = drc_pkg::log_tab_entry(gi, LOG_TABLE_BITS);
    end

    for (genvar gk = 0; gk < 16; gk++)
    begin : g_root_tab
        assign root_tab[gk] = drc_pkg::exp_root(gk + 1);
    end

    // registers
    logic [S-1:0]          mag_reg;
    logic                  neg_reg;
    logic [S-1:0]          norm_reg;
    logic [P_W-1:0]        p_reg;
    logic                  tiny_reg;
    logic [TW-1:0]         t0_reg;
    logic [TW-1:0]         dt_reg;
    logic [RW-1:0]         rem_reg;
    logic [TW:0]           y_reg;
    logic signed [LW-1:0]  level_reg;
    logic [LW-1:0]         red_reg;
    logic [COEF_BITS-1:0]  coef_reg;
    logic [ACC_W-1:0]      acc_reg;
    logic [drc_pkg::SMOOTH_W-1:0] sm_reg;
    logic [15:0]           f_reg;
    logic [5:0]            s_reg;
    logic [31:0]           m_reg;
    logic [3:0]            k_reg;
    logic [PROD_W-1:0]     prod_reg;
    logic [S-1:0]          out_sample_reg;
    logic                  clipped_reg;

    // next values
    logic [S-1:0]          mag_next;
    logic [P_W-1:0]        p_next;
    logic [S-1:0]          norm_next;
    logic [LOG_TABLE_BITS:0] idx0;
    logic [LOG_TABLE_BITS:0] idx1;
    logic [TW+RW-1:0]      interp_prod;
    logic [TW:0]           y_next;
    logic [LG_W-1:0]       lg_base;
    logic [LG_W-1:0]       lg_neg;
    logic [DBP_W-1:0]      db_sum;
    logic [DB_W-1:0]       db_neg;
    logic signed [LW-1:0]  level_next;
    logic signed [LW-1:0]  thr_ext;
    logic [LW-1:0]         exc;
    logic [LW-1:0]         ratio;
    logic [2*LW-1:0]       exc_prod;
    logic [LW-1:0]         red_next;
    logic [COEF_BITS-1:0]  coef_next;
    logic [SUM_W-1:0]      sm_sum;
    logic [drc_pkg::SMOOTH_W-1:0] sm_next;
    logic signed [17:0]    gain_db;
    logic signed [17:0]    gain_clamp;
    logic [14:0]           gain_pos;
    logic [36:0]           exp_prod;
    logic [21:0]           e2b;
    logic [63:0]           mc_prod;
    logic [31:0]           m_next;
    logic [RND_W-1:0]      rnd_sum;
    logic [RND_W-1:0]      res;
    logic [S-1:0]          res_mag;
    logic [S-1:0]          out_next;
    logic                  clip_next;

    // input magnitude
    assign mag_next = in_sample[S-1] ? S'(~in_sample + S'(1)) : in_sample;

    // leading one search and normalization
    always_comb
    begin
        p_next = '0;
        for (int b = 0; b < SAMPLE_BITS; b++)
        begin
            if (mag_reg[b])
            begin
                p_next = P_W'(b);
            end
        end
    end
    assign norm_next = mag_reg << (P_W'(SAMPLE_BITS - 1) - p_next);

    // table lookup and interpolation
    assign idx0        = {1'b0, norm_reg[S-2 -: LOG_TABLE_BITS]};
    assign idx1        = idx0 + (LOG_TABLE_BITS+1)'(1);
    assign interp_prod = dt_reg * rem_reg;
    assign y_next      = (TW+1)'(t0_reg) + (TW+1)'(interp_prod >> RW);

    // log2 to decibels
    assign lg_base = {P_W'(SAMPLE_BITS - 1) - p_reg, 16'd0};
    assign lg_neg  = (lg_base > LG_W'(y_reg)) ? lg_base - LG_W'(y_reg) : '0;
    assign db_sum  = DBP_W'(lg_neg) * DBP_W'(19'd394566) + (DBP_W'(1) << 23);
    assign db_neg  = db_sum[DBP_W-1:24];
    assign level_next = (tiny_reg || (LW'(db_neg) > LW'(30720)))
                        ? LEVEL_FLOOR : -$signed(LW'(db_neg));

    // gain reduction above threshold
    assign thr_ext  = LW'($signed(cfg.threshold_db));
    assign exc      = LW'(level_reg - thr_ext);
    assign ratio    = (cfg.inverse_ratio > drc_pkg::IRATIO_RST)
                      ? drc_pkg::IRATIO_RST : cfg.inverse_ratio;
    assign exc_prod = exc * ratio + (2*LW)'(32768);
    assign red_next = (level_reg > thr_ext) ? exc - LW'(exc_prod >> 16) : '0;

    // one-pole smoother
    assign coef_next = (red_reg > LW'(sm_reg)) ? COEF_BITS'(cfg.attack_coef)
                                               : COEF_BITS'(cfg.release_coef);
    assign sm_sum = SUM_W'(acc_reg) + SUM_W'(CONE - (COEF_BITS+1)'(coef_reg)) * SUM_W'(red_reg)
                    + SUM_W'(CONE >> 1);
    assign sm_next = sm_sum[COEF_BITS +: drc_pkg::SMOOTH_W];

    // decibel gain to log2 exponent
    assign gain_db    = $signed({5'd0, cfg.makeup_db}) - $signed({2'd0, sm_reg});
    assign gain_clamp = (gain_db < -18'sd16384) ? -18'sd16384 : gain_db;
    assign gain_pos   = 15'(gain_clamp + 18'sd16384);
    assign exp_prod   = 37'(gain_pos) * 37'(22'd2786636) + 37'(32768);
    assign e2b        = 22'(exp_prod >> 16) + 22'd351917;

    // one fractional exponent bit per cycle
    assign mc_prod = 64'(m_reg) * 64'(root_tab[k_reg]) + (64'd1 << 29);
    assign m_next  = f_reg[4'd15 - k_reg] ? 32'(mc_prod >> 30) : m_reg;

    // rounding, sign and saturation
    assign rnd_sum = RND_W'(prod_reg) + (RND_W'(1) << (s_reg - 6'd1));
    assign res     = rnd_sum >> s_reg;
    always_comb
    begin
        if (!neg_reg)
        begin
            clip_next = res > HALF_M1;
            res_mag   = clip_next ? HALF_M1_S : S'(res);
            out_next  = res_mag;
        end
        else
        begin
            clip_next = res > HALF;
            res_mag   = clip_next ? HALF_S : S'(res);
            out_next  = S'(~res_mag + S'(1));
        end
    end

    // smoother state and exponent counter
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sm_reg <= '0;
            k_reg  <= '0;
        end
        else
        begin
            if (cmd.op == drc_pkg::OP_SMB)
            begin
                sm_reg <= sm_next;
            end
            if (cmd.op == drc_pkg::OP_GAIN)
            begin
                k_reg <= '0;
            end
            else if (cmd.op == drc_pkg::OP_EXP)
            begin
                k_reg <= k_reg + 4'd1;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        unique case (cmd.op)
            drc_pkg::OP_LOAD:
            begin
                mag_reg <= mag_next;
                neg_reg <= in_sample[S-1];
            end
            drc_pkg::OP_NORM:
            begin
                norm_reg <= norm_next;
                p_reg    <= p_next;
                tiny_reg <= (mag_reg <= TINY_MAX);
            end
            drc_pkg::OP_TAB:
            begin
                t0_reg  <= log_tab[idx0];
                dt_reg  <= log_tab[idx1] - log_tab[idx0];
                rem_reg <= norm_reg[RW-1:0];
            end
            drc_pkg::OP_INTERP:
                y_reg <= y_next;
            drc_pkg::OP_DB:
                level_reg <= level_next;
            drc_pkg::OP_RED:
                red_reg <= red_next;
            drc_pkg::OP_SMA:
            begin
                coef_reg <= coef_next;
                acc_reg  <= ACC_W'(coef_next) * ACC_W'(sm_reg);
            end
            drc_pkg::OP_GAIN:
            begin
                f_reg <= e2b[15:0];
                s_reg <= 6'd46 - e2b[21:16];
                m_reg <= 32'd1 << 30;
            end
            drc_pkg::OP_EXP:
                m_reg <= m_next;
            drc_pkg::OP_PROD:
                prod_reg <= PROD_W'(mag_reg) * PROD_W'(m_reg);
            drc_pkg::OP_OUT:
            begin
                out_sample_reg <= out_next;
                clipped_reg    <= clip_next;
            end
            default:
            begin
                mag_reg <= mag_reg;
            end
        endcase
    end

    assign status.exp_last = (k_reg == 4'd15);
    assign out_sample      = out_sample_reg;
    assign clipped         = clipped_reg;

endmodule

// ===== rtl/core/drc_ctrl.sv =====
// sequencing state machine and output valid flag for the compressor
// depends on drc_pkg and the assertion macro header
`timescale 1ns / 1ps
`include "dynamic_range_compressor_unit_macros.svh"

module drc_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    output logic                out_valid,
    input  logic                out_ready,
    output drc_pkg::dp_cmd_t    cmd,
    input  drc_pkg::dp_status_t status
);

    drc_pkg::ctrl_state_t state_reg;
    drc_pkg::ctrl_state_t state_next;
    logic                 out_valid_reg;
    logic                 out_valid_next;

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= drc_pkg::ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // next state and datapath commands
    always_comb
    begin
        state_next     = state_reg;
        cmd.op         = drc_pkg::OP_NONE;
        in_ready       = 1'b0;
        out_valid_next = out_valid_reg & ~out_ready;
        unique case (state_reg)
            drc_pkg::ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.op     = drc_pkg::OP_LOAD;
                    state_next = drc_pkg::ST_NORM;
                end
            end
            drc_pkg::ST_NORM:
            begin
                cmd.op     = drc_pkg::OP_NORM;
                state_next = drc_pkg::ST_TAB;
            end
            drc_pkg::ST_TAB:
            begin
                cmd.op     = drc_pkg::OP_TAB;
                state_next = drc_pkg::ST_INTERP;
            end
            drc_pkg::ST_INTERP:
            begin
                cmd.op     = drc_pkg::OP_INTERP;
                state_next = drc_pkg::ST_DB;
            end
            drc_pkg::ST_DB:
            begin
                cmd.op     = drc_pkg::OP_DB;
                state_next = drc_pkg::ST_RED;
            end
            drc_pkg::ST_RED:
            begin
                cmd.op     = drc_pkg::OP_RED;
                state_next = drc_pkg::ST_SMA;
            end
            drc_pkg::ST_SMA:
            begin
                cmd.op     = drc_pkg::OP_SMA;
                state_next = drc_pkg::ST_SMB;
            end
            drc_pkg::ST_SMB:
            begin
                cmd.op     = drc_pkg::OP_SMB;
                state_next = drc_pkg::ST_GAIN;
            end
            drc_pkg::ST_GAIN:
            begin
                cmd.op     = drc_pkg::OP_GAIN;
                state_next = drc_pkg::ST_EXP;
            end
            drc_pkg::ST_EXP:
            begin
                cmd.op = drc_pkg::OP_EXP;
                if (status.exp_last)
                begin
                    state_next = drc_pkg::ST_PROD;
                end
            end
            drc_pkg::ST_PROD:
            begin
                cmd.op     = drc_pkg::OP_PROD;
                state_next = drc_pkg::ST_OUT;
            end
            drc_pkg::ST_OUT:
            begin
                // wait until the output register is free
                if (!out_valid_reg || out_ready)
                begin
                    cmd.op         = drc_pkg::OP_OUT;
                    out_valid_next = 1'b1;
                    state_next     = drc_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = drc_pkg::ST_IDLE;
            end
        endcase
    end

    assign out_valid = out_valid_reg;

    // sequencing checks
    `DRC_ASSERT_NXT(a_accept_starts, clk, rst_n, (state_reg == drc_pkg::ST_IDLE) && in_valid, state_reg == drc_pkg::ST_NORM, "accepted beat did not start processing")
    `DRC_ASSERT_NXT(a_exp_loops, clk, rst_n, (state_reg == drc_pkg::ST_EXP) && !status.exp_last, state_reg == drc_pkg::ST_EXP, "exponent loop left early")
    `DRC_ASSERT_NXT(a_out_loaded, clk, rst_n, (state_reg == drc_pkg::ST_OUT) && (!out_valid_reg || out_ready), out_valid_reg && (state_reg == drc_pkg::ST_IDLE), "result beat not presented")

endmodule

// ===== rtl/core/dynamic_range_compressor_unit.sv =====
// samples are processed one at a time: an input beat is accepted only in idle, after
//   the previous result has been loaded into the output register; the 16-step exponent
//   loop through the single 32x32 multiplier takes most of the processing of a sample
// a new input is taken while a finished result still waits in the output register
// reset: rst_n async active low sets config registers to defaults and the smoother to 0
`timescale 1ns / 1ps

module dynamic_range_compressor_unit #(
    parameter int SAMPLE_BITS    = drc_pkg::SAMPLE_BITS_DEF,
    parameter int COEF_BITS      = drc_pkg::COEF_BITS_DEF,
    parameter int LOG_TABLE_BITS = drc_pkg::LOG_TABLE_BITS_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    drc_in_if.sink                         in_ch,
    drc_out_if.source                      out_ch,
    input  logic                           cfg_we,
    input  logic [drc_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [drc_pkg::CFG_DATA_W-1:0] cfg_wdata
);

    drc_pkg::cfg_t       cfg;
    drc_pkg::dp_cmd_t    cmd;
    drc_pkg::dp_status_t status;
    logic [SAMPLE_BITS-1:0] out_sample;
    logic                   clipped;

    // configuration registers
    drc_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    // sequencer
    drc_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_ch.valid),
        .in_ready  (in_ch.ready),
        .out_valid (out_ch.valid),
        .out_ready (out_ch.ready),
        .cmd       (cmd),
        .status    (status)
    );

    // datapath
    drc_datapath #(
        .SAMPLE_BITS    (SAMPLE_BITS),
        .COEF_BITS      (COEF_BITS),
        .LOG_TABLE_BITS (LOG_TABLE_BITS)
    ) u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .status     (status),
        .cfg        (cfg),
        .in_sample  (in_ch.in_sample),
        .out_sample (out_sample),
        .clipped    (clipped)
    );

    assign out_ch.out_sample = out_sample;
    assign out_ch.clipped    = clipped;

endmodule

// ===== tb/tb_dynamic_range_compressor_unit.sv =====
// self-checking bench for dynamic_range_compressor_unit: directed table, then random phases
// depends on drc_pkg, drc_in_if, drc_out_if and the compressor rtl
`timescale 1ns / 1ps

module tb_dynamic_range_compressor_unit;
    import drc_pkg::*;

    localparam int SB         = SAMPLE_BITS_DEF;
    localparam int CYCLE_MAX  = 600000;
    localparam int HOLD_LEN   = 200;
    localparam int DRAIN_WAIT = 40;
    localparam int PHASES     = 8;
    localparam int PHASE_LEN  = 125;
    localparam longint DB_FLOOR = -30720;

    typedef enum logic [1:0] {ROW_SAMPLE, ROW_REG} row_kind_t;

    typedef struct {
        row_kind_t       kind;
        cfg_idx_t        idx;
        logic [16:0]     val;
        logic [SB-1:0]   smp;
        bit              typed;
        logic [SB-1:0]   out_smp;
        logic            out_clip;
    } stim_row_t;

    typedef struct {
        logic [SB-1:0] src;
        logic [SB-1:0] out_smp;
        logic          out_clip;
    } comp_beat_t;

    logic clk;
    logic rst_n;
    logic cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_wdata;

    drc_in_if  #(.SAMPLE_BITS(SB)) in_ch ();
    drc_out_if #(.SAMPLE_BITS(SB)) out_ch ();

    dynamic_range_compressor_unit dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_ch     (in_ch),
        .out_ch    (out_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    // register mirror and smoother state
    longint       thr_mirror;
    logic [16:0]  ratio_mirror;
    logic [15:0]  attack_mirror;
    logic [15:0]  release_mirror;
    logic [12:0]  makeup_mirror;
    logic [63:0]  smooth_red;

    logic [63:0]  log_tab [0:64];
    logic [63:0]  root_tab [1:16];

    comp_beat_t   pending_q [$];
    stim_row_t    dir_tab [$];

    int           errors;
    int           cycles;
    int           n_in;
    int           n_out;
    int           n_clip;
    int           n_settings;
    bit           idle_en;
    bit           hold_req;
    bit           use_typed;
    logic [SB-1:0] typed_smp;
    logic          typed_clip;

    // clock
    initial clk = 1'b0;
    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // fractional log2 of a Q1.30 mantissa by repeated squaring, Q.16 out
    function automatic logic [63:0] mant_log2(input logic [63:0] m_in);
        logic [63:0] m;
        logic [63:0] r;
        m = m_in;
        r = 0;
        if (m >= (64'd1 << 31))
            return 64'd65536;
        for (int k = 0; k < 16; k++)
        begin
            m = (m * m) >> 30;
            r = r << 1;
            if (m >= (64'd1 << 31))
            begin
                r = r | 64'd1;
                m = m >> 1;
            end
        end
        return r;
    endfunction

    function automatic logic [63:0] int_root(input logic [63:0] a_in);
        logic [63:0] a;
        logic [63:0] acc;
        logic [63:0] b;
        a   = a_in;
        acc = 0;
        b   = 64'd1 << 62;
        while (b > a)
            b = b >> 2;
        while (b != 0)
        begin
            if (a >= acc + b)
            begin
                a   = a - (acc + b);
                acc = (acc >> 1) + b;
            end
            else
                acc = acc >> 1;
            b = b >> 2;
        end
        return acc;
    endfunction

    // input level in Q8.8 dB
    function automatic longint level_of(input logic [63:0] mag);
        logic [63:0] norm;
        logic [63:0] frac;
        logic [63:0] idx;
        logic [63:0] rem;
        logic [63:0] y;
        logic [63:0] lg;
        logic [63:0] db;
        int          p;
        p = 0;
        if (mag * 64'd1000000 < (64'd1 << (SB - 1)))
            return DB_FLOOR;
        for (int b = 0; b < 40; b++)
            if (mag[b])
                p = b;
        norm = mag << (40 - p);
        frac = norm & ((64'd1 << 40) - 1);
        idx  = frac >> 34;
        rem  = frac & ((64'd1 << 34) - 1);
        y    = log_tab[idx] + (((log_tab[idx + 1] - log_tab[idx]) * rem) >> 34);
        lg   = 64'(SB - 1 - p) * 64'd65536;
        lg   = (lg > y) ? lg - y : 64'd0;
        db   = (lg * 64'd394566 + (64'd1 << 23)) >> 24;
        if (db > 64'd30720)
            return DB_FLOOR;
        return -longint'(db);
    endfunction

    // one sample through detector, smoother and gain stage; advances the smoother
    function automatic void compress(input logic [SB-1:0] x, output logic [SB-1:0] y,
                                     output logic clp);
        logic        neg;
        logic [63:0] mag;
        longint      lvl;
        logic [63:0] ex;
        logic [63:0] r;
        logic [63:0] red;
        logic [63:0] coef;
        longint      g;
        longint      e2;
        logic [63:0] e2b;
        longint      n;
        logic [63:0] f;
        logic [63:0] m;
        logic [63:0] res;
        int          s;
        neg = x[SB-1];
        mag = neg ? ((64'd1 << SB) - 64'(x)) : 64'(x);
        lvl = level_of(mag);
        red = 0;
        clp = 1'b0;
        if (lvl > thr_mirror)
        begin
            ex  = 64'(lvl - thr_mirror);
            r   = (ratio_mirror > 17'd65536) ? 64'd65536 : 64'(ratio_mirror);
            red = ex - ((ex * r + 64'd32768) >> 16);
        end
        coef = (red > smooth_red) ? 64'(attack_mirror) : 64'(release_mirror);
        smooth_red = ((coef * smooth_red + (64'd65536 - coef) * red + 64'd32768) >> 16)
                     & 64'hFFFF;
        g = longint'(makeup_mirror) - longint'(smooth_red);
        if (g < -16384)
            g = -16384;
        e2  = (((g + 16384) * 2786636 + 32768) >>> 16) - 696659;
        e2b = 64'(e2 + 1048576);
        n   = longint'(e2b >> 16) - 16;
        f   = e2b & 64'hFFFF;
        m   = 64'd1 << 30;
        for (int k = 1; k <= 16; k++)
            if (f[16 - k])
                m = (m * root_tab[k] + (64'd1 << 29)) >> 30;
        s   = int'(30 - n);
        res = (mag * m + (64'd1 << (s - 1))) >> s;
        if (!neg)
        begin
            if (res > (64'd1 << (SB - 1)) - 1)
            begin
                res = (64'd1 << (SB - 1)) - 1;
                clp = 1'b1;
            end
            y = res[SB-1:0];
        end
        else
        begin
            if (res > (64'd1 << (SB - 1)))
            begin
                res = 64'd1 << (SB - 1);
                clp = 1'b1;
            end
            y = SB'((64'd1 << SB) - res);
        end
    endfunction

    function automatic void mirror_reg(input cfg_idx_t idx, input logic [16:0] val);
        case (idx)
            CFG_THRESHOLD: thr_mirror     = longint'($signed(val[14:0]));
            CFG_INV_RATIO: ratio_mirror   = val;
            CFG_ATTACK:    attack_mirror  = val[15:0];
            CFG_RELEASE:   release_mirror = val[15:0];
            CFG_MAKEUP:    makeup_mirror  = val[12:0];
            default: ;
        endcase
    endfunction

    task automatic report(input string msg);
        errors++;
        if (errors <= 30)
            $display("%0t mismatch: %s", $time, msg);
    endtask

    // accepted input beats produce expectations
    always @(posedge clk)
    begin
        comp_beat_t b;
        if (rst_n && in_ch.valid && in_ch.ready)
        begin
            b.src = in_ch.in_sample;
            compress(in_ch.in_sample, b.out_smp, b.out_clip);
            if (use_typed)
            begin
                b.out_smp  = typed_smp;
                b.out_clip = typed_clip;
            end
            pending_q.push_back(b);
            n_in++;
        end
    end

    // result beats checked against the oldest expectation
    always @(posedge clk)
    begin
        comp_beat_t b;
        if (rst_n && out_ch.valid && out_ch.ready)
        begin
            n_out++;
            if (out_ch.clipped)
                n_clip++;
            if (pending_q.size() == 0)
                report($sformatf("result %h with nothing pending", out_ch.out_sample));
            else
            begin
                b = pending_q.pop_front();
                if (out_ch.out_sample !== b.out_smp)
                    report($sformatf("in %h: out_sample %h, want %h", b.src,
                                     out_ch.out_sample, b.out_smp));
                if (out_ch.clipped !== b.out_clip)
                    report($sformatf("in %h: clipped %b, want %b", b.src,
                                     out_ch.clipped, b.out_clip));
            end
        end
    end

    // receiver: random stall bursts and one long hold-off
    always
    begin
        @(negedge clk);
        if (hold_req)
        begin
            out_ch.ready <= 1'b0;
            repeat (HOLD_LEN) @(negedge clk);
            hold_req = 1'b0;
        end
        else if (idle_en && $urandom_range(0, 5) == 0)
        begin
            out_ch.ready <= 1'b0;
            repeat ($urandom_range(1, 9)) @(negedge clk);
        end
        else
            out_ch.ready <= 1'b1;
    end

    // watchdog
    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_MAX)
        begin
            $display("tb_dynamic_range_compressor_unit failed");
            $finish;
        end
    end

    task automatic send_beat(input logic [SB-1:0] s, input bit typed,
                             input logic [SB-1:0] t_smp, input logic t_clip);
        @(negedge clk);
        if (idle_en && $urandom_range(0, 4) == 0)
        begin
            in_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 9)) @(negedge clk);
        end
        in_ch.valid     <= 1'b1;
        in_ch.in_sample <= s;
        use_typed  = typed;
        typed_smp  = t_smp;
        typed_clip = t_clip;
        do
            @(posedge clk);
        while (!(in_ch.valid && in_ch.ready));
    endtask

    // sender stops until every pending result has come back
    task automatic drain();
        @(negedge clk);
        in_ch.valid <= 1'b0;
        while (pending_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);
    endtask

    task automatic write_reg(input cfg_idx_t idx, input logic [16:0] val);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        mirror_reg(idx, val);
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic add_row(input row_kind_t k, input cfg_idx_t idx, input logic [16:0] val,
                           input logic [SB-1:0] s, input bit typed,
                           input logic [SB-1:0] o, input logic c);
        stim_row_t r;
        r.kind = k;
        r.idx = idx;
        r.val = val;
        r.smp = s;
        r.typed = typed;
        r.out_smp = o;
        r.out_clip = c;
        dir_tab.push_back(r);
    endtask

    // random register setting for one phase; early phases hit the extremes
    task automatic pick_setting(input int ph);
        logic [16:0] v;
        case (ph)
            0: v = 17'(-15360);
            1: v = 17'd0;
            default: v = ($urandom_range(0, 7) == 0) ? 17'($urandom())
                                                     : 17'(-$urandom_range(0, 15360));
        endcase
        write_reg(CFG_THRESHOLD, v);
        case (ph)
            0: v = 17'd1;
            1: v = 17'd65536;
            default: v = ($urandom_range(0, 7) == 0) ? 17'($urandom())
                                                     : 17'($urandom_range(1, 65536));
        endcase
        write_reg(CFG_INV_RATIO, v);
        case (ph)
            0: v = 17'd0;
            1: v = 17'd65535;
            default: v = ($urandom_range(0, 3) == 0) ? 17'($urandom())
                                                     : 17'($urandom_range(60000, 65535));
        endcase
        write_reg(CFG_ATTACK, v);
        case (ph)
            0: v = 17'd65535;
            1: v = 17'd0;
            default: v = ($urandom_range(0, 3) == 0) ? 17'($urandom())
                                                     : 17'($urandom_range(64000, 65535));
        endcase
        write_reg(CFG_RELEASE, v);
        case (ph)
            0: v = 17'd7680;
            1: v = 17'd0;
            default: v = ($urandom_range(0, 7) == 0) ? 17'($urandom())
                                                     : 17'($urandom_range(0, 7680));
        endcase
        write_reg(CFG_MAKEUP, v);
        n_settings++;
    endtask

    initial
    begin
        logic signed [SB-1:0] v;
        int env;
        int sh;
        // mirror tables
        for (int i = 0; i <= 64; i++)
            log_tab[i] = mant_log2((64'd64 + 64'(i)) << 24);
        root_tab[1] = int_root((64'd1 << 31) << 30);
        for (int k = 2; k <= 16; k++)
            root_tab[k] = int_root(root_tab[k - 1] << 30);

        errors = 0; cycles = 0; n_in = 0; n_out = 0; n_clip = 0; n_settings = 1;
        idle_en = 1'b1; hold_req = 1'b0; use_typed = 1'b0;
        typed_smp = '0; typed_clip = 1'b0;
        thr_mirror = 0; ratio_mirror = IRATIO_RST; attack_mirror = '0;
        release_mirror = RELEASE_RST; makeup_mirror = '0; smooth_red = 0;
        rst_n = 1'b0; cfg_we = 1'b0; cfg_index = '0; cfg_wdata = '0;
        in_ch.valid = 1'b0; in_ch.in_sample = '0; out_ch.ready = 1'b0;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // reset settings pass samples through unchanged
        add_row(ROW_SAMPLE, CFG_THRESHOLD, 0, 24'd0, 1, 24'd0, 0);
        add_row(ROW_SAMPLE, CFG_THRESHOLD, 0, 24'd1, 1, 24'd1, 0);
        add_row(ROW_SAMPLE, CFG_THRESHOLD, 0, -24'sd1, 1, -24'sd1, 0);
        add_row(ROW_SAMPLE, CFG_THRESHOLD, 0, 24'd8, 1, 24'd8, 0);
        add_row(ROW_SAMPLE, CFG_THRESHOLD, 0, 24'd9, 1, 24'd9, 0);
        add_row(ROW_SAMPLE, CFG_THRESHOLD, 0, -24'sd9, 1, -24'sd9, 0);
        add_row(ROW_SAMPLE, CFG_THRESHOLD, 0, 24'h7FFFFF, 1, 24'h7FFFFF, 0);
        add_row(ROW_SAMPLE, CFG_THRESHOLD, 0, 24'h800000, 1, 24'h800000, 0);
        add_row(ROW_SAMPLE, CFG_THRESHOLD, 0, 24'h123456, 1, 24'h123456, 0);
        // full makeup drives full scale into saturation
        add_row(ROW_REG, CFG_MAKEUP, 17'd7680, 0, 0, 0, 0);
        add_row(ROW_SAMPLE, CFG_THRESHOLD, 0, 24'h7FFFFF, 1, 24'h7FFFFF, 1);
        add_row(ROW_SAMPLE, CFG_THRESHOLD, 0, 24'h800000, 1, 24'h800000, 1);
        add_row(ROW_SAMPLE, CFG_THRESHOLD, 0, 24'd0, 1, 24'd0, 0);
        add_row(ROW_SAMPLE, CFG_THRESHOLD, 0, 24'd1000, 0, 0, 0);
        add_row(ROW_SAMPLE, CFG_THRESHOLD, 0, -24'sd100000, 0, 0, 0);
        // deepest threshold, strongest ratio, instant attack
        add_row(ROW_REG, CFG_THRESHOLD, 17'(-15360), 0, 0, 0, 0);
        add_row(ROW_REG, CFG_INV_RATIO, 17'd1, 0, 0, 0, 0);
        add_row(ROW_REG, CFG_ATTACK, 17'd0, 0, 0, 0, 0);
        add_row(ROW_SAMPLE, CFG_THRESHOLD, 0, 24'h7FFFFF, 0, 0, 0);
        add_row(ROW_SAMPLE, CFG_THRESHOLD, 0, 24'd5, 0, 0, 0);
        add_row(ROW_SAMPLE, CFG_THRESHOLD, 0, -24'sd300000, 0, 0, 0);
        // out-of-range settings: ratio above one, positive threshold, oversized makeup
        add_row(ROW_REG, CFG_INV_RATIO, 17'h1FFFF, 0, 0, 0, 0);
        add_row(ROW_REG, CFG_THRESHOLD, 17'h3FFF, 0, 0, 0, 0);
        add_row(ROW_REG, CFG_MAKEUP, 17'h1FFF, 0, 0, 0, 0);
        add_row(ROW_REG, CFG_RELEASE, 17'd65535, 0, 0, 0, 0);
        add_row(ROW_SAMPLE, CFG_THRESHOLD, 0, 24'h800001, 0, 0, 0);
        add_row(ROW_SAMPLE, CFG_THRESHOLD, 0, 24'd20, 0, 0, 0);

        // directed table
        foreach (dir_tab[i])
        begin
            if (dir_tab[i].kind == ROW_REG)
            begin
                drain();
                write_reg(dir_tab[i].idx, dir_tab[i].val);
                n_settings++;
            end
            else
                send_beat(dir_tab[i].smp, dir_tab[i].typed, dir_tab[i].out_smp,
                          dir_tab[i].out_clip);
        end
        drain();

        // random phases with an envelope so attack and release both act
        env = 0;
        for (int ph = 0; ph < PHASES; ph++)
        begin
            if (ph == PHASES - 1)
                idle_en = 1'b0;
            pick_setting(ph);
            for (int i = 0; i < PHASE_LEN; i++)
            begin
                if (ph == 2 && i == 40)
                    hold_req = 1'b1;
                if ($urandom_range(0, 29) == 0)
                    env = $urandom_range(0, 23);
                case ($urandom_range(0, 19))
                    0: v = 24'h7FFFFF;
                    1: v = 24'h800000;
                    default:
                    begin
                        sh = env + $urandom_range(0, 2);
                        v  = SB'($urandom());
                        v  = v >>> ((sh > 23) ? 23 : sh);
                    end
                endcase
                send_beat(v, 0, 0, 0);
            end
            drain();
        end

        $display("%0d samples in, %0d results out, %0d saturated", n_in, n_out, n_clip);
        $display("%0d register settings, long output hold-off and full drains included",
                 n_settings);
        if (errors == 0)
            $display("tb_dynamic_range_compressor_unit passed");
        else
            $display("tb_dynamic_range_compressor_unit failed");
        $finish;
    end

endmodule
